### sv/tsps_pkg.sv
// Shared types, codes and the CRC byte function of the temperature sensor poll sequencer.
package tsps_pkg;

  typedef enum logic [2:0] {
    PH_RESET1  = 3'd0,
    PH_SKIP1   = 3'd1,
    PH_CONVERT = 3'd2,
    PH_WAIT    = 3'd3,
    PH_RESET2  = 3'd4,
    PH_SKIP2   = 3'd5,
    PH_READCMD = 3'd6,
    PH_READ    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ACT_RESET = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WAIT  = 2'd3
  } action_t;

  localparam logic [7:0] CMD_SKIP    = 8'hCC;
  localparam logic [7:0] CMD_CONVERT = 8'h44;
  localparam logic [7:0] CMD_READ    = 8'hBE;

  localparam logic [15:0] WAIT_RESET = 16'd200;

  localparam logic signed [11:0] TEMP_MIN   = -12'sd50;
  localparam logic signed [11:0] TEMP_MAX   = 12'sd120;
  localparam logic signed [11:0] TEMP_POWER = 12'sd85;

  localparam logic [7:0] CRC_FEED = 8'h18;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // Per-sensor fields without a reset value
  typedef struct packed {
    logic [15:0] wait_time;
    logic [3:0]  byte_index;
    logic [7:0]  running_crc;
    logic [7:0]  low_byte;
    logic [7:0]  high_byte;
  } work_t;

  // Full per-sensor state as seen by the step logic
  typedef struct packed {
    phase_t            phase;
    logic signed [11:0] stored_temp;
    logic              temp_present;
    work_t             work;
  } entry_t;

  typedef struct packed {
    action_t           bus_action;
    logic [7:0]        write_data;
    logic signed [11:0] temperature;
    logic              temp_valid;
    logic              crc_error;
  } result_t;

  // Reflected CRC-8, polynomial 0x31, one byte LSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] d_in);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = d_in;
    for (int k = 0; k < 8; k++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = ((c ^ CRC_FEED) >> 1) | CRC_TOP;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

### sv/tsps_step.sv
// Next-state and result logic for one step of one sensor's poll sequence.
module tsps_step #(
  parameter int SCRATCH_BYTES = 9
) (
  input  tsps_pkg::entry_t  cur,
  input  logic [9:0]        elapsed_ms,
  input  logic              presence,
  input  logic [7:0]        read_data,
  input  logic [15:0]       conversion_wait_ms,
  output tsps_pkg::entry_t  nxt,
  output tsps_pkg::result_t res
);
  import tsps_pkg::*;

  logic [16:0] wait_sum;
  logic [15:0] wait_sat;
  logic [4:0]  idx_inc;
  logic        last_byte;
  logic [15:0] raw;

  assign wait_sum  = {1'b0, cur.work.wait_time} + 17'(elapsed_ms);
  assign wait_sat  = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
  assign idx_inc   = {1'b0, cur.work.byte_index} + 5'd1;
  assign last_byte = (idx_inc >= 5'(SCRATCH_BYTES));

  always_comb begin
    nxt            = cur;
    res.bus_action = ACT_WAIT;
    res.write_data = 8'h00;
    res.crc_error  = 1'b0;
    raw            = 16'h0000;
    unique case (cur.phase)
      PH_RESET1, PH_RESET2: begin
        res.bus_action = ACT_RESET;
        if (!presence) begin
          nxt.temp_present = 1'b0;
          nxt.stored_temp  = '0;
          nxt.phase        = PH_RESET1;
        end else begin
          nxt.phase = (cur.phase == PH_RESET1) ? PH_SKIP1 : PH_SKIP2;
        end
      end
      PH_SKIP1, PH_SKIP2: begin
        res.bus_action = ACT_WRITE;
        res.write_data = CMD_SKIP;
        nxt.phase      = (cur.phase == PH_SKIP1) ? PH_CONVERT : PH_READCMD;
      end
      PH_CONVERT: begin
        res.bus_action     = ACT_WRITE;
        res.write_data     = CMD_CONVERT;
        nxt.work.wait_time = 16'h0000;
        nxt.phase          = PH_WAIT;
      end
      PH_WAIT: begin
        nxt.work.wait_time = wait_sat;
        if (wait_sat >= conversion_wait_ms) begin
          nxt.phase = PH_RESET2;
        end
      end
      PH_READCMD: begin
        res.bus_action       = ACT_WRITE;
        res.write_data       = CMD_READ;
        nxt.work.byte_index  = 4'd0;
        nxt.work.running_crc = 8'h00;
        nxt.phase            = PH_READ;
      end
      PH_READ: begin
        res.bus_action = ACT_READ;
        if (cur.work.byte_index == 4'd0) begin
          nxt.work.low_byte = read_data;
        end
        if (cur.work.byte_index == 4'd1) begin
          nxt.work.high_byte = read_data;
        end
        // use the freshly taken bytes: a short scratchpad ends on byte one
        raw = {nxt.work.high_byte, nxt.work.low_byte};
        if (last_byte) begin
          if (read_data == cur.work.running_crc) begin
            nxt.stored_temp  = raw[15:4];
            nxt.temp_present = 1'b1;
          end else begin
            nxt.stored_temp  = '0;
            nxt.temp_present = 1'b0;
            res.crc_error    = 1'b1;
          end
          nxt.work.byte_index = 4'd0;
          nxt.phase           = PH_RESET1;
        end else begin
          nxt.work.running_crc = crc_byte(cur.work.running_crc, read_data);
          nxt.work.byte_index  = idx_inc[3:0];
        end
      end
      default: begin
        nxt.phase = PH_RESET1;
      end
    endcase
    res.temperature = nxt.temp_present ? nxt.stored_temp : 12'sd0;
    res.temp_valid  = nxt.temp_present && (nxt.stored_temp >= TEMP_MIN) &&
                      (nxt.stored_temp <= TEMP_MAX) && (nxt.stored_temp != TEMP_POWER);
  end

endmodule

### sv/temp_sensor_poll_sequencer_top.sv
// Top level of the temperature sensor poll sequencer: item stage, sensor state, result register.
//
//   channel  | ports                               | word layout, low bit first
//   in       | in_tvalid  in_tready  in_tdata[23:0]| sensor, elapsed_ms, presence, read_data
//   out      | out_tvalid out_tready out_tdata[23:0]| bus_action, write_data, temperature,
//            |                                     | temp_valid, crc_error
//   cfg      | cfg_wr_en  cfg_wr_data[15:0]        | conversion_wait_ms
//
// One word a cycle unless the output stalls; words pass the item stage, then the result register.
// The per-sensor state is read and written back in the one step cycle, so back-to-back
// words for the same sensor need no bypass.
// Reset (rst_n low, synchronous) returns every sensor to the first reset phase and
// drops all stored temperatures. A stalled output holds its word; the item stage then
// fills and in_tready falls.
module temp_sensor_poll_sequencer_top #(
  parameter int NUM_SENSORS   = 5,
  parameter int SCRATCH_BYTES = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // sensor[2:0], elapsed_ms[12:3], presence[13], read_data[21:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // bus_action[1:0], write_data[9:2], temperature[21:10],
                                  // temp_valid[22], crc_error[23]
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import tsps_pkg::*;

  localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic [15:0] cfg_wait_r;

  logic       busy_r, busy_nxt;
  logic [2:0] sensor_r;
  logic [9:0] elapsed_r;
  logic       presence_r;
  logic [7:0] rdata_r;

  phase_t             phase_r   [NUM_SENSORS];
  logic signed [11:0] temp_r    [NUM_SENSORS];
  logic               present_r [NUM_SENSORS];
  work_t              work_r    [NUM_SENSORS];

  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_data_r;

  logic              advance, fire, in_range;
  logic [SIDX_W-1:0] sidx;
  entry_t            cur, nxt;
  result_t           res, res_sel;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = busy_r && advance;
  assign in_tready = !busy_r || advance;
  assign in_range  = (5'(sensor_r) < 5'(NUM_SENSORS));
  assign sidx      = SIDX_W'(sensor_r);

  always_comb begin
    cur = '0;
    if (in_range) begin
      cur.phase        = phase_r[sidx];
      cur.stored_temp  = temp_r[sidx];
      cur.temp_present = present_r[sidx];
      cur.work         = work_r[sidx];
    end
  end

  tsps_step #(
    .SCRATCH_BYTES(SCRATCH_BYTES)
  ) u_step (
    .cur               (cur),
    .elapsed_ms        (elapsed_r),
    .presence          (presence_r),
    .read_data         (rdata_r),
    .conversion_wait_ms(cfg_wait_r),
    .nxt               (nxt),
    .res               (res)
  );

  // Out-of-range sensor: report a wait, touch nothing
  always_comb begin
    if (in_range) begin
      res_sel = res;
    end else begin
      res_sel            = '0;
      res_sel.bus_action = ACT_WAIT;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_tvalid && in_tready) begin
      busy_nxt = 1'b1;
    end else if (fire) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_wait_r  <= WAIT_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_wait_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sensor_r   <= in_tdata[2:0];
      elapsed_r  <= in_tdata[12:3];
      presence_r <= in_tdata[13];
      rdata_r    <= in_tdata[21:14];
    end
    if (fire) begin
      out_data_r <= {res_sel.crc_error, res_sel.temp_valid, res_sel.temperature,
                     res_sel.write_data, res_sel.bus_action};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        phase_r[i]   <= PH_RESET1;
        temp_r[i]    <= '0;
        present_r[i] <= 1'b0;
      end
    end else if (fire && in_range) begin
      phase_r[sidx]   <= nxt.phase;
      temp_r[sidx]    <= nxt.stored_temp;
      present_r[sidx] <= nxt.temp_present;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_range) begin
      work_r[sidx] <= nxt.work;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A word in the stage always reaches the output register once it may advance
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("step result not registered");

  // A blocked stage keeps its word
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !advance) |=> (busy_r && $stable(sensor_r) && $stable(rdata_r)))
    else $error("stalled item lost or changed");

  // Write data is non-zero exactly on write actions
  a_write_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[1:0] == ACT_WRITE) == (out_data_r[9:2] != 8'h00)))
    else $error("write data does not match bus action");

  // A CRC failure comes only on a read and leaves no valid temperature
  a_crc_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[23]) |-> ((out_data_r[1:0] == ACT_READ) && !out_data_r[22]))
    else $error("crc error outside a read");

endmodule
